/* rtl/u8gm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u8gm_pkg;

	typedef enum logic [1:0] {
		CS_STD  = 2'd0,
		CS_INTL = 2'd1,
		CS_TERM = 2'd2,
		CS_RSVD = 2'd3
	} char_set_t;

	typedef enum logic [1:0] {
		REG_CHAR_SET   = 2'd0,
		REG_ERR_GLYPH  = 2'd1,
		REG_ERR_ATTR   = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	localparam logic [7:0] SPACE_GLYPH  = 8'h20;
	localparam logic [7:0] INVERSE_ATTR = 8'h80;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
		logic [7:0] attr;
	} glyph_t;

	function automatic glyph_t std_lookup(input logic [20:0] cp);
		glyph_t r;
		r = '{1'b1, 8'h00, 8'h00};
		case (cp)
			21'h0000A0: r = '{1'b1, 8'h20, 8'h00};
			21'h002665: r = '{1'b1, 8'h00, 8'h00};
			21'h00251C: r = '{1'b1, 8'h01, 8'h00};
			21'h002518: r = '{1'b1, 8'h03, 8'h00};
			21'h002524: r = '{1'b1, 8'h04, 8'h00};
			21'h002510: r = '{1'b1, 8'h05, 8'h00};
			21'h002571: r = '{1'b1, 8'h06, 8'h00};
			21'h002572: r = '{1'b1, 8'h07, 8'h00};
			21'h0025E2: r = '{1'b1, 8'h08, 8'h00};
			21'h002597: r = '{1'b1, 8'h09, 8'h00};
			21'h0025E3: r = '{1'b1, 8'h0A, 8'h00};
			21'h00259D: r = '{1'b1, 8'h0B, 8'h00};
			21'h002598: r = '{1'b1, 8'h0C, 8'h00};
			21'h002582: r = '{1'b1, 8'h0E, 8'h00};
			21'h002596: r = '{1'b1, 8'h0F, 8'h00};
			21'h002663: r = '{1'b1, 8'h10, 8'h00};
			21'h00250C: r = '{1'b1, 8'h11, 8'h00};
			21'h002500: r = '{1'b1, 8'h12, 8'h00};
			21'h00253C: r = '{1'b1, 8'h13, 8'h00};
			21'h002022: r = '{1'b1, 8'h14, 8'h00};
			21'h002584: r = '{1'b1, 8'h15, 8'h00};
			21'h00258E: r = '{1'b1, 8'h16, 8'h00};
			21'h00252C: r = '{1'b1, 8'h17, 8'h00};
			21'h002534: r = '{1'b1, 8'h18, 8'h00};
			21'h00258C: r = '{1'b1, 8'h19, 8'h00};
			21'h002514: r = '{1'b1, 8'h1A, 8'h00};
			21'h00241B: r = '{1'b1, 8'h1B, 8'h00};
			21'h002191: r = '{1'b1, 8'h1C, 8'h00};
			21'h002193: r = '{1'b1, 8'h1D, 8'h00};
			21'h002190: r = '{1'b1, 8'h1E, 8'h00};
			21'h002192: r = '{1'b1, 8'h1F, 8'h00};
			21'h002666: r = '{1'b1, 8'h60, 8'h00};
			21'h002660: r = '{1'b1, 8'h7B, 8'h00};
			21'h0025C0: r = '{1'b1, 8'h7E, 8'h00};
			21'h0025B6: r = '{1'b1, 8'h7F, 8'h00};
			21'h00258A: r = '{1'b1, 8'h02, 8'h80};
			21'h0025E4: r = '{1'b1, 8'h08, 8'h80};
			21'h00259B: r = '{1'b1, 8'h09, 8'h80};
			21'h0025E5: r = '{1'b1, 8'h0A, 8'h80};
			21'h002599: r = '{1'b1, 8'h0B, 8'h80};
			21'h00259F: r = '{1'b1, 8'h0C, 8'h80};
			21'h002586: r = '{1'b1, 8'h0D, 8'h80};
			21'h00259C: r = '{1'b1, 8'h0F, 8'h80};
			21'h0025D8: r = '{1'b1, 8'h14, 8'h80};
			21'h002580: r = '{1'b1, 8'h15, 8'h80};
			21'h002590: r = '{1'b1, 8'h19, 8'h80};
			21'h002588: r = '{1'b1, 8'h20, 8'h80};
			default:    r = '{1'b0, SPACE_GLYPH, INVERSE_ATTR};
		endcase
		return r;
	endfunction

	function automatic glyph_t intl_lookup(input logic [20:0] cp);
		glyph_t r;
		r = '{1'b1, 8'h00, 8'h00};
		case (cp)
			21'h0000A0: r = '{1'b1, 8'h20, 8'h00};
			21'h0000E1: r = '{1'b1, 8'h00, 8'h00};
			21'h0000F9: r = '{1'b1, 8'h01, 8'h00};
			21'h0000D1: r = '{1'b1, 8'h02, 8'h00};
			21'h0000C9: r = '{1'b1, 8'h03, 8'h00};
			21'h0000E7: r = '{1'b1, 8'h04, 8'h00};
			21'h0000F4: r = '{1'b1, 8'h05, 8'h00};
			21'h0000F2: r = '{1'b1, 8'h06, 8'h00};
			21'h0000EC: r = '{1'b1, 8'h07, 8'h00};
			21'h0000A3: r = '{1'b1, 8'h08, 8'h00};
			21'h0000EF: r = '{1'b1, 8'h09, 8'h00};
			21'h0000FC: r = '{1'b1, 8'h0A, 8'h00};
			21'h0000E4: r = '{1'b1, 8'h0B, 8'h00};
			21'h0000D6: r = '{1'b1, 8'h0C, 8'h00};
			21'h0000FA: r = '{1'b1, 8'h0D, 8'h00};
			21'h0000F3: r = '{1'b1, 8'h0E, 8'h00};
			21'h0000F6: r = '{1'b1, 8'h0F, 8'h00};
			21'h0000DC: r = '{1'b1, 8'h10, 8'h00};
			21'h0000E2: r = '{1'b1, 8'h11, 8'h00};
			21'h0000FB: r = '{1'b1, 8'h12, 8'h00};
			21'h0000EE: r = '{1'b1, 8'h13, 8'h00};
			21'h0000E9: r = '{1'b1, 8'h14, 8'h00};
			21'h0000E8: r = '{1'b1, 8'h15, 8'h00};
			21'h0000F1: r = '{1'b1, 8'h16, 8'h00};
			21'h0000EA: r = '{1'b1, 8'h17, 8'h00};
			21'h0000E5: r = '{1'b1, 8'h18, 8'h00};
			21'h000032: r = '{1'b1, 8'h19, 8'h00};
			21'h0000C5: r = '{1'b1, 8'h1A, 8'h00};
			21'h0000A1: r = '{1'b1, 8'h60, 8'h00};
			21'h0000C4: r = '{1'b1, 8'hFB, 8'h00};
			21'h00241B: r = '{1'b1, 8'h1B, 8'h00};
			21'h002191: r = '{1'b1, 8'h1C, 8'h00};
			21'h002193: r = '{1'b1, 8'h1D, 8'h00};
			21'h002190: r = '{1'b1, 8'h1E, 8'h00};
			21'h002192: r = '{1'b1, 8'h1F, 8'h00};
			21'h0025C0: r = '{1'b1, 8'h7E, 8'h00};
			21'h0025B6: r = '{1'b1, 8'h7F, 8'h00};
			default:    r = '{1'b0, SPACE_GLYPH, INVERSE_ATTR};
		endcase
		return r;
	endfunction

	function automatic glyph_t term_lookup(input logic [20:0] cp);
		glyph_t r;
		r = '{1'b1, 8'h00, 8'h00};
		case (cp)
			21'h000132: r = '{1'b1, 8'h00, 8'h00};
			21'h0021E7: r = '{1'b1, 8'h01, 8'h00};
			21'h0000F8: r = '{1'b1, 8'h02, 8'h00};
			21'h0000A3: r = '{1'b1, 8'h03, 8'h00};
			21'h0029BB: r = '{1'b1, 8'h04, 8'h00};
			21'h0000A8: r = '{1'b1, 8'h05, 8'h00};
			21'h0000B0: r = '{1'b1, 8'h06, 8'h00};
			21'h0000A7: r = '{1'b1, 8'h07, 8'h00};
			21'h0000C7: r = '{1'b1, 8'h08, 8'h00};
			21'h0000D1: r = '{1'b1, 8'h09, 8'h00};
			21'h0000C6: r = '{1'b1, 8'h0A, 8'h00};
			21'h0000C4: r = '{1'b1, 8'h0B, 8'h00};
			21'h0000D6: r = '{1'b1, 8'h0C, 8'h00};
			21'h0000C5: r = '{1'b1, 8'h0D, 8'h00};
			21'h0000DC: r = '{1'b1, 8'h0E, 8'h00};
			21'h000152: r = '{1'b1, 8'h0F, 8'h00};
			21'h000133: r = '{1'b1, 8'h10, 8'h00};
			21'h0000DF: r = '{1'b1, 8'h11, 8'h00};
			21'h0000E0: r = '{1'b1, 8'h12, 8'h00};
			21'h0000E8: r = '{1'b1, 8'h13, 8'h00};
			21'h0000EC: r = '{1'b1, 8'h14, 8'h00};
			21'h0000EF: r = '{1'b1, 8'h15, 8'h00};
			21'h0000F9: r = '{1'b1, 8'h16, 8'h00};
			21'h0000E9: r = '{1'b1, 8'h17, 8'h00};
			21'h0000E7: r = '{1'b1, 8'h18, 8'h00};
			21'h0000F1: r = '{1'b1, 8'h19, 8'h00};
			21'h0000E6: r = '{1'b1, 8'h1A, 8'h00};
			21'h0000E4: r = '{1'b1, 8'h1B, 8'h00};
			21'h0000F6: r = '{1'b1, 8'h1C, 8'h00};
			21'h0000E5: r = '{1'b1, 8'h1D, 8'h00};
			21'h0000FC: r = '{1'b1, 8'h1E, 8'h00};
			21'h000153: r = '{1'b1, 8'h1F, 8'h00};
			default:    r = '{1'b0, SPACE_GLYPH, INVERSE_ATTR};
		endcase
		return r;
	endfunction

	function automatic glyph_t map_short(input char_set_t cs, input logic [20:0] cp);
		glyph_t r;
		case (cs)
			CS_TERM: r = term_lookup(cp);
			CS_INTL: r = intl_lookup(cp);
			default: r = std_lookup(cp);
		endcase
		return r;
	endfunction

	function automatic glyph_t map_long(input char_set_t cs, input logic [20:0] cp,
			input logic [7:0] err_code, input logic [7:0] err_attr);
		glyph_t r;
		r = '{1'b0, err_code, err_attr};
		case (cs)
			CS_INTL: begin
				if (cp == 21'h01F8B0) r = '{1'b1, 8'h7D, 8'h00};
			end
			CS_TERM: r = '{1'b0, err_code, err_attr};
			default: begin
				case (cp)
					21'h01FB87: r = '{1'b1, 8'h02, 8'h00};
					21'h01FB82: r = '{1'b1, 8'h0D, 8'h00};
					21'h01F8B0: r = '{1'b1, 8'h7D, 8'h00};
					default:    r = '{1'b0, err_code, err_attr};
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/utf8_to_glyph_code_mapper_top.sv */
// channel  | handshake          | payload
// in       | in_valid/in_ready  | byte_in
// out      | out_valid/out_ready| kind, glyph_code, glyph_attribute
// cfg      | apb psel/penable   | paddr[3:0], pwdata, prdata
//
// one byte per cycle sustained while the output is not stalled
// the input register feeds the decoder, whose state and result register update together
// a stalled result register holds the input stage, even for bytes that give no result
// arst_n clears the decoder to idle, the registers to their defaults, both stages empty
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_glyph_code_mapper_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [7:0]       glyph_code,
	output logic [7:0]       glyph_attribute,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import u8gm_pkg::*;

	char_set_t   char_set_q;
	logic [7:0]  err_glyph_q;
	logic [7:0]  err_attr_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	logic [1:0]  seq_len_q;
	logic [1:0]  idx_q;
	logic [20:0] acc_q;

	logic        out_valid_s2;
	logic        kind_s2;
	logic [7:0]  code_s2;
	logic [7:0]  attr_s2;

	logic [1:0]  seq_len_d;
	logic [1:0]  idx_d;
	logic [20:0] acc_d;
	logic        emit;
	logic        kind_d;
	logic [7:0]  code_d;
	logic [7:0]  attr_d;
	logic [1:0]  idx_inc;
	logic [20:0] acc_n;
	logic [20:0] part;
	glyph_t      g;
	reg_idx_t    widx;

	assign widx = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_set_q  <= CS_STD;
			err_glyph_q <= 8'h00;
			err_attr_q  <= INVERSE_ATTR;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_CHAR_SET:  char_set_q  <= char_set_t'(pwdata[1:0]);
				REG_ERR_GLYPH: err_glyph_q <= pwdata[7:0];
				REG_ERR_ATTR:  err_attr_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_CHAR_SET:  prdata = {30'b0, char_set_q};
			REG_ERR_GLYPH: prdata = {24'b0, err_glyph_q};
			REG_ERR_ATTR:  prdata = {24'b0, err_attr_q};
			default:       prdata = 32'b0;
		endcase
	end

	assign adv      = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		idx_inc = idx_q + 2'd1;
		case (2'(seq_len_q - idx_inc))
			2'd0:    part = {15'b0, byte_s1[5:0]};
			2'd1:    part = {9'b0, byte_s1[5:0], 6'b0};
			2'd2:    part = {3'b0, byte_s1[5:0], 12'b0};
			default: part = {byte_s1[2:0], 18'b0};
		endcase
		acc_n = acc_q | part;
		if (seq_len_q == 2'd3) g = map_long(char_set_q, acc_n, err_glyph_q, err_attr_q);
		else g = map_short(char_set_q, acc_n);

		seq_len_d = seq_len_q;
		idx_d     = idx_q;
		acc_d     = acc_q;
		emit      = 1'b0;
		kind_d    = 1'b0;
		code_d    = byte_s1;
		attr_d    = 8'h00;
		if (seq_len_q == 2'd0) begin
			idx_d = 2'd0;
			if (!byte_s1[7]) begin
				emit = 1'b1;
			end else if (byte_s1[7:5] == 3'b110) begin
				seq_len_d = 2'd1;
				acc_d     = {10'b0, byte_s1[4:0], 6'b0};
			end else if (byte_s1[7:4] == 4'b1110) begin
				seq_len_d = 2'd2;
				acc_d     = {5'b0, byte_s1[3:0], 12'b0};
			end else if (byte_s1[7:3] == 5'b11110) begin
				seq_len_d = 2'd3;
				acc_d     = {byte_s1[2:0], 18'b0};
			end
		end else if (byte_s1[7:6] != 2'b10) begin
			seq_len_d = 2'd0;
			idx_d     = 2'd0;
		end else begin
			acc_d = acc_n;
			idx_d = idx_inc;
			if (idx_inc >= seq_len_q) begin
				seq_len_d = 2'd0;
				idx_d     = 2'd0;
				emit      = 1'b1;
				kind_d    = 1'b1;
				code_d    = g.code;
				attr_d    = g.attr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			seq_len_q    <= 2'd0;
			idx_q        <= 2'd0;
			acc_q        <= 21'd0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) begin
				seq_len_q    <= seq_len_d;
				idx_q        <= idx_d;
				acc_q        <= acc_d;
				out_valid_s2 <= emit;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= byte_in;
		if (adv && emit) begin
			kind_s2 <= kind_d;
			code_s2 <= code_d;
			attr_s2 <= attr_d;
		end
	end

	assign out_valid       = out_valid_s2;
	assign kind            = kind_s2;
	assign glyph_code      = code_s2;
	assign glyph_attribute = attr_s2;

`ifndef SYNTHESIS
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q == 2'd0 |-> idx_q == 2'd0)
		else $error("continuation count set while idle");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q != 2'd0 |-> idx_q < seq_len_q)
		else $error("continuation count beyond sequence length");
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> glyph_attribute == 8'h00 && !glyph_code[7])
		else $error("plain result with high byte or attribute");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a stalled byte");
`endif

endmodule

`default_nettype wire
